### src/assert_macros.svh
// Assertion helpers for the sphere vertex unit checkers.
// Both expect signals named clk_i and rst_ni in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define UVSQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check that an expression never holds outside reset.
`define UVSQ_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

### src/uvsq_pkg.sv
package uvsq_pkg;

  localparam int FracBits   = 14;
  localparam int MaxDiv     = 256;
  localparam int CntW       = 9;
  localparam int RadW       = 10;
  localparam int IdxW       = 8;
  localparam int TexW       = 17;
  localparam int NormW      = 16;
  localparam int PosW       = 25;
  localparam int ThetaShift = 33;
  localparam int PhiShift   = 32;
  localparam int DivBits    = 6;
  localparam int DivStages  = (CntW + ThetaShift + DivBits - 1) / DivBits;
  localparam int SinStages  = 8;

  localparam logic [31:0] Quarter = 32'h4000_0000;

  // (pi/2)^n / n! in Q30
  localparam logic [30:0] Tay9 = 31'd172272;
  localparam logic [30:0] TayCoef [4] = '{31'd5026995, 31'd85569306,
                                          31'd693598668, 31'd1686629713};

  typedef enum logic [1:0] {
    RegRadius   = 2'd0,
    RegBands    = 2'd1,
    RegSegments = 2'd2,
    RegNone     = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic       valid;
    logic [1:0] corner;
    logic       bad;
  } tag_t;

  typedef struct packed {
    logic [TexW-1:0] tex_u;
    logic [TexW-1:0] tex_v;
  } side_t;

endpackage

### src/uvsq_div.sv
module uvsq_div #(
  parameter int Shift = 33
) (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [uvsq_pkg::CntW-1:0] num_i,
  input  logic [uvsq_pkg::CntW-1:0] den_i,
  output logic [uvsq_pkg::CntW+Shift-1:0] quo_o
);
  import uvsq_pkg::*;

  localparam int NumW = CntW + Shift;
  localparam int PadW = DivStages * DivBits;

  logic [CntW-1:0] rem_q [DivStages];
  logic [PadW-1:0] quo_q [DivStages];
  logic [CntW-1:0] num_q [DivStages];

  for (genvar s = 0; s < DivStages; s++) begin : g_stage
    logic [CntW-1:0] rem_d;
    logic [PadW-1:0] quo_d;
    logic [CntW-1:0] num_in;
    logic [CntW-1:0] rem_in;
    logic [PadW-1:0] quo_in;

    if (s == 0) begin : g_first
      assign num_in = num_i;
      assign rem_in = '0;
      assign quo_in = '0;
    end else begin : g_rest
      assign num_in = num_q[s-1];
      assign rem_in = rem_q[s-1];
      assign quo_in = quo_q[s-1];
    end

    // Restoring division, a few quotient bits per stage
    always_comb begin
      logic [PadW-1:0] full;
      logic [CntW:0]   t;
      logic [CntW-1:0] rem;
      logic [PadW-1:0] q;
      rem  = rem_in;
      q    = quo_in;
      full = PadW'(num_in) << Shift;
      for (int j = 0; j < DivBits; j++) begin
        t = {rem, full[PadW-1-s*DivBits-j]};
        q = {q[PadW-2:0], 1'b0};
        if (t >= {1'b0, den_i}) begin
          t    = t - {1'b0, den_i};
          q[0] = 1'b1;
        end
        rem = t[CntW-1:0];
      end
      rem_d = rem;
      quo_d = q;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= rem_d;
        quo_q[s] <= quo_d;
        num_q[s] <= num_in;
      end
    end
  end

  assign quo_o = quo_q[DivStages-1][NumW-1:0];

endmodule

### src/uvsq_sin.sv
module uvsq_sin (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic [31:0]                       phase_i,
  output logic signed [uvsq_pkg::NormW-1:0] val_o
);
  import uvsq_pkg::*;

  localparam int RndShift = 60 - FracBits;

  logic [1:0]  q0_q, q1_q, q6_q;
  logic [30:0] x0_q, x1_q, x2_1_q;
  logic [1:0]  qh_q  [4];
  logic [30:0] xh_q  [4];
  logic [30:0] x2h_q [4];
  logic [30:0] sh_q  [4];
  logic [61:0] prod_q;
  logic signed [NormW-1:0] val_q;

  logic [30:0] x0_d;
  logic [61:0] sq;
  logic [61:0] prod_d;
  logic [62:0] rnd;
  logic [16:0] mag;
  logic [16:0] sat;

  // Fold the phase into the first quarter turn
  always_comb begin
    if (phase_i[30]) x0_d = 31'(Quarter) - {1'b0, phase_i[29:0]};
    else             x0_d = {1'b0, phase_i[29:0]};
  end

  assign sq = 62'(x0_q) * 62'(x0_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q0_q   <= phase_i[31:30];
      x0_q   <= x0_d;
      q1_q   <= q0_q;
      x1_q   <= x0_q;
      x2_1_q <= sq[60:30];
    end
  end

  // Horner steps of the odd series, one multiply per stage
  for (genvar k = 0; k < 4; k++) begin : g_horner
    logic [30:0] s_in, x_in, x2_in;
    logic [1:0]  q_in;
    logic [61:0] p;
    logic [31:0] s_next;
    if (k == 0) begin : g_first
      assign s_in  = Tay9;
      assign x_in  = x1_q;
      assign x2_in = x2_1_q;
      assign q_in  = q1_q;
    end else begin : g_rest
      assign s_in  = sh_q[k-1];
      assign x_in  = xh_q[k-1];
      assign x2_in = x2h_q[k-1];
      assign q_in  = qh_q[k-1];
    end
    assign p      = 62'(x2_in) * 62'(s_in);
    assign s_next = {1'b0, TayCoef[k]} - p[61:30];
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sh_q[k]  <= s_next[30:0];
        xh_q[k]  <= x_in;
        x2h_q[k] <= x2_in;
        qh_q[k]  <= q_in;
      end
    end
  end

  assign prod_d = 62'(xh_q[3]) * 62'(sh_q[3]);

  // Round half up, saturate at one, negate in the lower half turn
  always_comb begin
    rnd = {1'b0, prod_q} + (63'(1) << (RndShift - 1));
    mag = 17'(rnd >> RndShift);
    if (mag > 17'(1 << FracBits)) sat = 17'(1 << FracBits);
    else                           sat = mag;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q6_q   <= qh_q[3];
      prod_q <= prod_d;
      if (q6_q[1]) val_q <= -$signed(NormW'(sat));
      else         val_q <= $signed(NormW'(sat));
    end
  end

  assign val_o = val_q;

endmodule

### src/uv_sphere_quad_vertices_unit.sv
// A quad passes the holding, divider, phase, sine, normal and output registers.
// The next quad is taken as the held one issues its last corner; the output
// carries one vertex word per cycle when not stalled, the four corners in order.
// A stall on the output freezes the whole pipeline; nothing is lost or repeated.
// Reset clears all valid bits and loads radius 1, 16 bands and 16 segments.
module uv_sphere_quad_vertices_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [1:0]                        cfg_idx_i,
  input  logic [uvsq_pkg::RadW-1:0]         cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [uvsq_pkg::IdxW-1:0]         band_index_i,
  input  logic [uvsq_pkg::IdxW-1:0]         segment_index_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [1:0]                        corner_o,
  output logic [uvsq_pkg::TexW-1:0]         tex_u_o,
  output logic [uvsq_pkg::TexW-1:0]         tex_v_o,
  output logic signed [uvsq_pkg::NormW-1:0] normal_x_o,
  output logic signed [uvsq_pkg::NormW-1:0] normal_y_o,
  output logic signed [uvsq_pkg::NormW-1:0] normal_z_o,
  output logic signed [uvsq_pkg::PosW-1:0]  pos_x_o,
  output logic signed [uvsq_pkg::PosW-1:0]  pos_y_o,
  output logic signed [uvsq_pkg::PosW-1:0]  pos_z_o,
  output logic                              out_of_range_o,
  output logic                              last_o
);
  import uvsq_pkg::*;

  localparam int ThetaQW = CntW + ThetaShift;
  localparam int PhiQW   = CntW + PhiShift;
  localparam int ProdW   = 2 * NormW;

  // Configuration registers
  logic [RadW-1:0] radius_q;
  logic [CntW-1:0] bands_q, segs_q;
  logic [CntW-1:0] cnt_sat;

  assign cnt_sat = (cfg_data_i[CntW-1:0] > CntW'(MaxDiv)) ? CntW'(MaxDiv)
                                                          : cfg_data_i[CntW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RadW'(1);
      bands_q  <= CntW'(16);
      segs_q   <= CntW'(16);
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        RegRadius:   radius_q <= cfg_data_i;
        RegBands:    bands_q  <= cnt_sat;
        RegSegments: segs_q   <= cnt_sat;
        default: ;
      endcase
    end
  end

  // Pipeline advance
  logic adv;
  logic out_valid_q;
  assign adv = !out_valid_q || out_ready_i;

  // Quad holding register: issue one corner per advance
  logic            hold_valid_q;
  logic [IdxW-1:0] hold_i_q, hold_o_q;
  logic [1:0]      cnt_q;
  logic            emit, last_emit, in_acc, hold_bad;
  logic [CntW-1:0] vert_a, vert_b;

  assign emit       = hold_valid_q && adv;
  assign last_emit  = emit && (cnt_q == 2'd3);
  assign in_ready_o = !hold_valid_q || last_emit;
  assign in_acc     = in_valid_i && in_ready_o;
  assign hold_bad   = ({1'b0, hold_i_q} >= bands_q) || ({1'b0, hold_o_q} >= segs_q);
  assign vert_a     = {1'b0, hold_o_q} + CntW'(cnt_q[1]);
  assign vert_b     = {1'b0, hold_i_q} + CntW'(cnt_q[1] ^ cnt_q[0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_valid_q <= 1'b0;
      cnt_q        <= 2'd0;
    end else begin
      if (in_acc)         hold_valid_q <= 1'b1;
      else if (last_emit) hold_valid_q <= 1'b0;
      if (emit)           cnt_q <= cnt_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      hold_i_q <= band_index_i;
      hold_o_q <= segment_index_i;
    end
  end

  // Angle quotients
  logic [ThetaQW-1:0] qt;
  logic [PhiQW-1:0]   qp;

  uvsq_div #(.Shift(ThetaShift)) u_div_theta (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (vert_a),
    .den_i (segs_q),
    .quo_o (qt)
  );

  uvsq_div #(.Shift(PhiShift)) u_div_phi (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (vert_b),
    .den_i (bands_q),
    .quo_o (qp)
  );

  tag_t div_tag_q [DivStages];
  tag_t emit_tag;
  assign emit_tag = '{valid: emit, corner: cnt_q, bad: hold_bad};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < DivStages; s++) div_tag_q[s] <= '0;
    end else if (adv) begin
      div_tag_q[0] <= emit_tag;
      for (int s = 1; s < DivStages; s++) div_tag_q[s] <= div_tag_q[s-1];
    end
  end

  // Round quotients into phases and texture coordinates
  logic [ThetaQW:0]       pt_sum;
  logic [PhiQW:0]         pp_sum;
  logic [ThetaQW-ThetaShift+TexW:0] tu_sum;
  logic [PhiQW-PhiShift+TexW:0]     tv_sum;
  logic [31:0]            pt_q, pp_q;
  tag_t                   p_tag_q;
  side_t                  p_side_q;

  assign pt_sum = {1'b0, qt} + (ThetaQW+1)'(1);
  assign pp_sum = {1'b0, qp} + (PhiQW+1)'(1);
  assign tu_sum = {1'b0, qt[ThetaQW-1:ThetaShift-TexW]} + (ThetaQW-ThetaShift+TexW+1)'(1);
  assign tv_sum = {1'b0, qp[PhiQW-1:PhiShift-TexW]} + (PhiQW-PhiShift+TexW+1)'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_tag_q <= '0;
    end else if (adv) begin
      p_tag_q <= div_tag_q[DivStages-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pt_q           <= pt_sum[32:1];
      pp_q           <= pp_sum[32:1];
      p_side_q.tex_u <= tu_sum[TexW:1];
      p_side_q.tex_v <= tv_sum[TexW:1];
    end
  end

  // Sine and cosine of both angles
  logic signed [NormW-1:0] st, ct, sp, cp;

  uvsq_sin u_sin_t (.clk_i(clk_i), .en_i(adv), .phase_i(pt_q), .val_o(st));
  uvsq_sin u_cos_t (.clk_i(clk_i), .en_i(adv), .phase_i(pt_q + Quarter), .val_o(ct));
  uvsq_sin u_sin_p (.clk_i(clk_i), .en_i(adv), .phase_i(pp_q), .val_o(sp));
  uvsq_sin u_cos_p (.clk_i(clk_i), .en_i(adv), .phase_i(pp_q + Quarter), .val_o(cp));

  tag_t  sin_tag_q  [SinStages];
  side_t sin_side_q [SinStages];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < SinStages; s++) sin_tag_q[s] <= '0;
    end else if (adv) begin
      sin_tag_q[0] <= p_tag_q;
      for (int s = 1; s < SinStages; s++) sin_tag_q[s] <= sin_tag_q[s-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sin_side_q[0] <= p_side_q;
      for (int s = 1; s < SinStages; s++) sin_side_q[s] <= sin_side_q[s-1];
    end
  end

  // Product of two unit values, rounded half away from zero
  function automatic logic signed [NormW-1:0] mul_round(
    input logic signed [NormW-1:0] a,
    input logic signed [NormW-1:0] b
  );
    logic signed [ProdW-1:0] p;
    logic [ProdW-1:0]        m;
    p = a * b;
    m = p[ProdW-1] ? ProdW'(-p) : ProdW'(p);
    m = (m + ProdW'(1 << (FracBits - 1))) >> FracBits;
    mul_round = p[ProdW-1] ? -$signed(NormW'(m)) : $signed(NormW'(m));
  endfunction

  tag_t                    n_tag_q;
  side_t                   n_side_q;
  logic signed [NormW-1:0] nx_q, ny_q, nz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_tag_q <= '0;
    end else if (adv) begin
      n_tag_q <= sin_tag_q[SinStages-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      n_side_q <= sin_side_q[SinStages-1];
      nx_q     <= mul_round(ct, sp);
      ny_q     <= cp;
      nz_q     <= mul_round(st, sp);
    end
  end

  // Output register: scale by radius, zero an out-of-range quad
  logic signed [RadW:0]      rad_s;
  logic signed [RadW+NormW:0] px, py, pz;
  logic [1:0]                corner_q;
  logic                      bad_q;
  logic [TexW-1:0]           tu_q, tv_q;
  logic signed [NormW-1:0]   onx_q, ony_q, onz_q;
  logic signed [PosW-1:0]    opx_q, opy_q, opz_q;

  assign rad_s = $signed({1'b0, radius_q});
  assign px    = rad_s * nx_q;
  assign py    = rad_s * ny_q;
  assign pz    = rad_s * nz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= n_tag_q.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      corner_q <= n_tag_q.corner;
      bad_q    <= n_tag_q.bad;
      if (n_tag_q.bad) begin
        tu_q  <= '0;
        tv_q  <= '0;
        onx_q <= '0;
        ony_q <= '0;
        onz_q <= '0;
        opx_q <= '0;
        opy_q <= '0;
        opz_q <= '0;
      end else begin
        tu_q  <= n_side_q.tex_u;
        tv_q  <= n_side_q.tex_v;
        onx_q <= nx_q;
        ony_q <= ny_q;
        onz_q <= nz_q;
        opx_q <= px[PosW-1:0];
        opy_q <= py[PosW-1:0];
        opz_q <= pz[PosW-1:0];
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign corner_o       = corner_q;
  assign tex_u_o        = tu_q;
  assign tex_v_o        = tv_q;
  assign normal_x_o     = onx_q;
  assign normal_y_o     = ony_q;
  assign normal_z_o     = onz_q;
  assign pos_x_o        = opx_q;
  assign pos_y_o        = opy_q;
  assign pos_z_o        = opz_q;
  assign out_of_range_o = bad_q;
  assign last_o         = (corner_q == 2'd3);

endmodule

### src/uvsq_checker.sv
`include "assert_macros.svh"

module uvsq_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input logic [1:0]                        corner_o,
  input logic [uvsq_pkg::TexW-1:0]         tex_u_o,
  input logic signed [uvsq_pkg::NormW-1:0] normal_x_o,
  input logic signed [uvsq_pkg::NormW-1:0] normal_y_o,
  input logic signed [uvsq_pkg::NormW-1:0] normal_z_o,
  input logic signed [uvsq_pkg::PosW-1:0]  pos_x_o,
  input logic                              out_of_range_o,
  input logic                              last_o
);

  // A stalled word holds
  `UVSQ_ASSERT(a_stall_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(corner_o) && $stable(pos_x_o), "stalled vertex word changed")

  // Corners of one quad leave back to back
  `UVSQ_ASSERT(a_corner_seq, out_valid_o && out_ready_i && !last_o |=> out_valid_o && (corner_o == $past(corner_o) + 2'd1), "corner sequence broken")

  // Last flag marks the fourth corner
  `UVSQ_NEVER(a_last_flag, out_valid_o && (last_o != (corner_o == 2'd3)), "last flag mismatch")

  // Out-of-range words carry zero geometry
  `UVSQ_NEVER(a_bad_zero, out_valid_o && out_of_range_o && ((normal_x_o != 0) || (normal_y_o != 0) || (normal_z_o != 0) || (tex_u_o != 0)), "out-of-range word not cleared")

endmodule

bind uv_sphere_quad_vertices_unit uvsq_checker u_uvsq_checker (.*);

### tb/sv/uvsq_vertex_checker.sv
`timescale 1ns / 1ps

module uvsq_vertex_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [1:0]                        cfg_idx_i,
  input  logic [uvsq_pkg::RadW-1:0]         cfg_data_i,
  input  logic                              in_valid_i,
  input  logic                              in_ready_i,
  input  logic [uvsq_pkg::IdxW-1:0]         band_index_i,
  input  logic [uvsq_pkg::IdxW-1:0]         segment_index_i,
  input  logic                              out_valid_i,
  input  logic                              out_ready_i,
  input  logic [1:0]                        corner_i,
  input  logic [uvsq_pkg::TexW-1:0]         tex_u_i,
  input  logic [uvsq_pkg::TexW-1:0]         tex_v_i,
  input  logic signed [uvsq_pkg::NormW-1:0] normal_x_i,
  input  logic signed [uvsq_pkg::NormW-1:0] normal_y_i,
  input  logic signed [uvsq_pkg::NormW-1:0] normal_z_i,
  input  logic signed [uvsq_pkg::PosW-1:0]  pos_x_i,
  input  logic signed [uvsq_pkg::PosW-1:0]  pos_y_i,
  input  logic signed [uvsq_pkg::PosW-1:0]  pos_z_i,
  input  logic                              out_of_range_i,
  input  logic                              last_i,
  output int                                pending_o,
  output int                                errors_o
);
  import uvsq_pkg::*;

  typedef struct packed {
    logic [1:0]              corner;
    logic [TexW-1:0]         tex_u;
    logic [TexW-1:0]         tex_v;
    logic signed [NormW-1:0] nx;
    logic signed [NormW-1:0] ny;
    logic signed [NormW-1:0] nz;
    logic signed [PosW-1:0]  px;
    logic signed [PosW-1:0]  py;
    logic signed [PosW-1:0]  pz;
    logic                    oor;
    logic                    last;
  } vertex_t;

  vertex_t     vertex_q[$];
  logic [9:0]  radius_q;
  logic [8:0]  bands_q;
  logic [8:0]  segs_q;

  // Taylor series of sin(pi/2*x) over one quarter turn, x in Q30
  function automatic longint quarter_sine(longint unsigned x);
    longint unsigned x2, s, v;
    x2 = (x * x) >> 30;
    s = 172272;
    s = 64'd5026995 - ((x2 * s) >> 30);
    s = 64'd85569306 - ((x2 * s) >> 30);
    s = 64'd693598668 - ((x2 * s) >> 30);
    s = 64'd1686629713 - ((x2 * s) >> 30);
    v = ((x * s) + (64'd1 << (59 - FracBits))) >> (60 - FracBits);
    if (v > (64'd1 << FracBits)) v = 64'd1 << FracBits;
    return longint'(v);
  endfunction

  function automatic longint phase_sine(logic [31:0] phase);
    longint unsigned r;
    longint m;
    r = phase[29:0];
    if (phase[30]) r = 64'h4000_0000 - r;
    m = quarter_sine(r);
    return phase[31] ? -m : m;
  endfunction

  // Product rounded to FracBits, halves away from zero
  function automatic longint scaled_product(longint a, longint b);
    longint p;
    longint unsigned m;
    p = a * b;
    m = (p < 0) ? longint'(-p) : p;
    m = (m + (64'd1 << (FracBits - 1))) >> FracBits;
    return (p < 0) ? -longint'(m) : longint'(m);
  endfunction

  function automatic vertex_t sphere_vertex(int k, logic bad, int a, int b);
    vertex_t v;
    longint unsigned ns, nb;
    logic [31:0] pt, pp;
    longint st, ct, sp, cp, nx, nz, r;
    v = '0;
    v.corner = k[1:0];
    v.last = (k == 3);
    if (bad) begin
      v.oor = 1'b1;
      return v;
    end
    ns = segs_q;
    nb = bands_q;
    pt = 32'(((longint'(a) << 33) + ns) / (2 * ns));
    pp = 32'(((longint'(b) << 32) + nb) / (2 * nb));
    st = phase_sine(pt);
    ct = phase_sine(pt + 32'h4000_0000);
    sp = phase_sine(pp);
    cp = phase_sine(pp + 32'h4000_0000);
    nx = scaled_product(ct, sp);
    nz = scaled_product(st, sp);
    r = radius_q;
    v.tex_u = TexW'(((longint'(a) << 17) + ns) / (2 * ns));
    v.tex_v = TexW'(((longint'(b) << 17) + nb) / (2 * nb));
    v.nx = NormW'(nx);
    v.ny = NormW'(cp);
    v.nz = NormW'(nz);
    v.px = PosW'(r * nx);
    v.py = PosW'(r * cp);
    v.pz = PosW'(r * nz);
    return v;
  endfunction

  function automatic logic [8:0] clamp_count(logic [RadW-1:0] d);
    return (d[8:0] > MaxDiv) ? 9'(MaxDiv) : d[8:0];
  endfunction

  // Report one field mismatch
  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors_o++;
    end
  endtask

  assign pending_o = vertex_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    int i, o;
    logic bad;
    vertex_t w;
    if (!rst_ni) begin
      radius_q <= 10'd1;
      bands_q  <= 9'd16;
      segs_q   <= 9'd16;
      vertex_q.delete();
      errors_o = 0;
    end else begin
      // Track register writes
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          RegRadius:   radius_q <= cfg_data_i;
          RegBands:    bands_q  <= clamp_count(cfg_data_i);
          RegSegments: segs_q   <= clamp_count(cfg_data_i);
          default: ;
        endcase
      end
      // Predict four vertices per accepted quad
      if (in_valid_i && in_ready_i) begin
        i = band_index_i;
        o = segment_index_i;
        bad = (i >= bands_q) || (o >= segs_q);
        vertex_q = {vertex_q, sphere_vertex(0, bad, o, i)};
        vertex_q = {vertex_q, sphere_vertex(1, bad, o, i + 1)};
        vertex_q = {vertex_q, sphere_vertex(2, bad, o + 1, i + 1)};
        vertex_q = {vertex_q, sphere_vertex(3, bad, o + 1, i)};
      end
      // Compare each output word against the oldest vertex
      if (out_valid_i && out_ready_i) begin
        if (vertex_q.size() == 0) begin
          $error("vertex word with nothing expected");
          errors_o++;
        end else begin
          w = vertex_q.pop_front();
          check_field("corner", w.corner, corner_i);
          check_field("tex_u", w.tex_u, tex_u_i);
          check_field("tex_v", w.tex_v, tex_v_i);
          check_field("normal_x", w.nx, normal_x_i);
          check_field("normal_y", w.ny, normal_y_i);
          check_field("normal_z", w.nz, normal_z_i);
          check_field("pos_x", w.px, pos_x_i);
          check_field("pos_y", w.py, pos_y_i);
          check_field("pos_z", w.pz, pos_z_i);
          check_field("out_of_range", w.oor, out_of_range_i);
          check_field("last", w.last, last_i);
        end
      end
    end
  end

endmodule

### tb/sv/uv_sphere_quad_vertices_unit_test.sv
`timescale 1ns / 1ps

module uv_sphere_quad_vertices_unit_test;
  import uvsq_pkg::*;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     cfg_we_i = 1'b0;
  logic [1:0]               cfg_idx_i = RegRadius;
  logic [RadW-1:0]          cfg_data_i = '0;
  logic                     in_valid_i = 1'b0;
  logic                     in_ready_o;
  logic [IdxW-1:0]          band_index_i = '0;
  logic [IdxW-1:0]          segment_index_i = '0;
  logic                     out_valid_o;
  logic                     out_ready_i = 1'b0;
  logic [1:0]               corner_o;
  logic [TexW-1:0]          tex_u_o, tex_v_o;
  logic signed [NormW-1:0]  normal_x_o, normal_y_o, normal_z_o;
  logic signed [PosW-1:0]   pos_x_o, pos_y_o, pos_z_o;
  logic                     out_of_range_o, last_o;
  int                       pending, errors;
  logic                     hold_off = 1'b0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  uv_sphere_quad_vertices_unit u_top (.*);

  uvsq_vertex_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_ready_i(in_ready_o), .band_index_i, .segment_index_i,
    .out_valid_i(out_valid_o), .out_ready_i, .corner_i(corner_o),
    .tex_u_i(tex_u_o), .tex_v_i(tex_v_o),
    .normal_x_i(normal_x_o), .normal_y_i(normal_y_o), .normal_z_i(normal_z_o),
    .pos_x_i(pos_x_o), .pos_y_i(pos_y_o), .pos_z_i(pos_z_o),
    .out_of_range_i(out_of_range_o), .last_i(last_o),
    .pending_o(pending), .errors_o(errors)
  );

  function automatic int gap_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Offer one quad word and hold it until accepted; valid stays up for a
  // following word with no gap
  task automatic send_quad(logic [7:0] band, logic [7:0] seg);
    int g;
    g = gap_length();
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    band_index_i    <= band;
    segment_index_i <= seg;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // Drop valid and wait for every expected vertex word
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [RadW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_shape(logic [RadW-1:0] rad, logic [RadW-1:0] nb,
                           logic [RadW-1:0] ns);
    write_reg(RegRadius, rad);
    write_reg(RegBands, nb);
    write_reg(RegSegments, ns);
    @(posedge clk_i);
  endtask

  // Mostly in-range quads, some out of range, a few with random bits
  task automatic random_quads(int n, int nb, int ns);
    int r;
    repeat (n) begin
      r = $urandom_range(0, 9);
      if (r < 7)
        send_quad(8'($urandom_range(0, nb - 1)), 8'($urandom_range(0, ns - 1)));
      else if (r < 9)
        send_quad(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      else
        send_quad(8'(nb > 255 ? 255 : nb), 8'($urandom_range(0, ns - 1)));
    end
  endtask

  // Receiver: random stalls, one long hold-off on request
  always @(posedge clk_i) begin
    if (hold_off) out_ready_i <= 1'b0;
    else if ($urandom_range(0, 3) == 0) out_ready_i <= (gap_length() == 0);
    else out_ready_i <= 1'b1;
  end

  initial begin
    #4000000;
    $display("uv_sphere_quad_vertices_unit_test: FAIL");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);

    // Directed quads at reset shape
    send_quad(8'd0, 8'd0);
    send_quad(8'd15, 8'd15);
    send_quad(8'd16, 8'd0);
    send_quad(8'd0, 8'd16);
    send_quad(8'd255, 8'd255);
    send_quad(8'd7, 8'd3);
    send_quad(8'd8, 8'd12);
    drain();

    // Largest radius, saturated counts, index extremes
    set_shape(10'd1023, 10'd511, 10'd300);
    send_quad(8'd255, 8'd255);
    send_quad(8'd0, 8'd255);
    send_quad(8'd255, 8'd0);
    send_quad(8'd128, 8'd64);
    send_quad(8'hAA, 8'h55);
    send_quad(8'h55, 8'hAA);
    drain();

    // Smallest counts, zero radius
    set_shape(10'd0, 10'd1, 10'd1);
    send_quad(8'd0, 8'd0);
    send_quad(8'd1, 8'd0);
    send_quad(8'd0, 8'd1);
    drain();

    // Zero counts always fall out of range; unused register index ignored
    set_shape(10'd5, 10'd0, 10'd0);
    write_reg(RegNone, 10'h3FF);
    send_quad(8'd0, 8'd0);
    drain();

    // Long output hold-off while quads keep coming
    set_shape(10'd77, 10'd3, 10'd7);
    fork
      begin
        hold_off <= 1'b1;
        repeat (120) @(posedge clk_i);
        hold_off <= 1'b0;
      end
      random_quads(20, 3, 7);
    join
    drain();

    set_shape(10'd1, 10'd16, 10'd16);
    random_quads(60, 16, 16);
    drain();
    set_shape(10'd512, 10'd256, 10'd256);
    random_quads(70, 256, 256);
    drain();
    set_shape(10'($urandom_range(0, 1023)), 10'd37, 10'd200);
    random_quads(60, 37, 200);
    drain();
    set_shape(10'd1023, 10'd2, 10'd255);
    random_quads(40, 2, 255);
    drain();

    if (errors == 0)
      $display("uv_sphere_quad_vertices_unit_test: PASS");
    else
      $display("uv_sphere_quad_vertices_unit_test: FAIL");
    $finish;
  end

endmodule

### uv_sphere_quad_vertices_unit.f
+incdir+src
src/uvsq_pkg.sv
src/uvsq_div.sv
src/uvsq_sin.sv
src/uv_sphere_quad_vertices_unit.sv
src/uvsq_checker.sv
tb/sv/uvsq_vertex_checker.sv
tb/sv/uv_sphere_quad_vertices_unit_test.sv
